// ===== design/sorted_cell_note_table_macros.svh =====
// Assertion macros shared by the sorted cell note table.
`ifndef SORTED_CELL_NOTE_TABLE_MACROS_SVH
`define SORTED_CELL_NOTE_TABLE_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define STC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted cell note table: same-cycle check failed");

// Next-cycle implication.
`define STC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted cell note table: next-cycle check failed");

`endif

// ===== design/stc_pkg.sv =====
`timescale 1ns / 1ps
package stc_pkg;

  localparam int POOL_ENTRIES = 64;
  localparam int ADDR_W = $clog2(POOL_ENTRIES);
  localparam int LINK_W = 7;
  localparam int CNT_W = 7;
  localparam logic [LINK_W-1:0] LINK_NULL = 7'h7F;
  localparam logic [7:0] ROW_NONE = 8'hFF;

  localparam logic [2:0] MODE_LOOKUP    = 3'd0;
  localparam logic [2:0] MODE_SET       = 3'd1;
  localparam logic [2:0] MODE_CLEAR     = 3'd2;
  localparam logic [2:0] MODE_CLEAR_ALL = 3'd3;
  localparam logic [2:0] MODE_NEXT_ROW  = 3'd4;
  localparam logic [2:0] MODE_COUNT     = 3'd5;
  localparam logic [2:0] MODE_LIST_ROW  = 3'd6;
  localparam logic [2:0] MODE_LIST_ALL  = 3'd7;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] note_code;
    logic [7:0] velocity;
    logic [7:0] effect;
    logic [7:0] effect_param;
  } in_item_t;

  typedef struct packed {
    logic             valid_res;
    logic [7:0]       out_row;
    logic [7:0]       out_col;
    logic [7:0]       out_note;
    logic [7:0]       out_velocity;
    logic [7:0]       out_effect;
    logic [7:0]       out_param;
    logic [CNT_W-1:0] entry_count;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              kd_we;
    logic [ADDR_W-1:0] kd_addr;
    logic [15:0]       wr_key;
    logic [31:0]       wr_data;
    logic              lk_we;
    logic [ADDR_W-1:0] lk_addr;
    logic [LINK_W-1:0] wr_link;
    logic              lk_clear;
  } pool_req_t;

  typedef struct packed {
    logic [15:0]       key;
    logic [31:0]       data;
    logic [LINK_W-1:0] link;
  } pool_rsp_t;

  function automatic logic slot_ok(input logic [LINK_W-1:0] l);
    return l < LINK_W'(POOL_ENTRIES);
  endfunction

  // Link of an untouched slot: chain to the next slot, last slot to null.
  function automatic logic [LINK_W-1:0] link_reset(input logic [ADDR_W-1:0] a);
    int n;
    n = int'(a) + 1;
    return (n < POOL_ENTRIES) ? LINK_W'(n) : LINK_NULL;
  endfunction

endpackage

// ===== design/stc_pool.sv =====
`timescale 1ns / 1ps
module stc_pool (
  input  logic              clk,
  input  logic              rst_n,
  input  stc_pkg::pool_req_t req,
  output stc_pkg::pool_rsp_t rsp
);

  logic [15:0]               key_mem  [stc_pkg::POOL_ENTRIES];
  logic [31:0]               data_mem [stc_pkg::POOL_ENTRIES];
  logic [stc_pkg::LINK_W-1:0] link_mem [stc_pkg::POOL_ENTRIES];
  logic [stc_pkg::POOL_ENTRIES-1:0] link_vld_r;

  always_ff @(posedge clk) begin
    if (req.kd_we) begin
      key_mem[req.kd_addr]  <= req.wr_key;
      data_mem[req.kd_addr] <= req.wr_data;
    end
    if (req.lk_we) begin
      link_mem[req.lk_addr] <= req.wr_link;
    end
  end

  // A slot whose link was never written reads as the free chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r <= '0;
    end else if (req.lk_clear) begin
      link_vld_r <= '0;
    end else if (req.lk_we) begin
      link_vld_r[req.lk_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rsp.key  <= key_mem[req.rd_addr];
      rsp.data <= data_mem[req.rd_addr];
      rsp.link <= link_vld_r[req.rd_addr] ? link_mem[req.rd_addr]
                                          : stc_pkg::link_reset(req.rd_addr);
    end
  end

endmodule

// ===== design/sorted_cell_note_table.sv =====
`timescale 1ns / 1ps
// Sparse note table keyed by (row, col), kept as a sorted linked list in a
// pool of stc_pkg::POOL_ENTRIES slots with a free list.
// Input channel: in_valid / in_stall / in_data (in_item_t). A transaction is
// taken when in_valid is high and in_stall low; in_stall stays high until all
// results of the item have been handed to the output register.
// Output channel: out_valid / out_stall / out_data (out_item_t). Every mode
// gives one result with last set, except the listings, which give one result
// per matching entry (or one invalid result when nothing matches).
// Walk: the sequencer walks the list through one pool read port, reading each
// entry visited in S_RD and checking it in S_CHK. Clear all and count need
// no walk; a listing can also wait while the output is stalled.
// Reset: table empty, all slots free; no clearing pass is needed.
// A stalled output holds its transaction; the walk waits whenever a new result
// is ready and the output register still holds a stalled result.
module sorted_cell_note_table (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  stc_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output stc_pkg::out_item_t out_data
);

  `include "sorted_cell_note_table_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CHK, S_DEC, S_FREE, S_PATCH, S_RESP
  } state_t;

  typedef enum logic [2:0] {
    OP_LOOK, OP_SET, OP_DEL, OP_NEXT, OP_LIST
  } op_t;

  localparam int AW = stc_pkg::ADDR_W;
  localparam int LW = stc_pkg::LINK_W;
  localparam int CW = stc_pkg::CNT_W;

  stc_pkg::pool_req_t req;
  stc_pkg::pool_rsp_t rsp;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   all_r, all_nxt;
  logic [15:0] key_r, key_nxt;
  logic [31:0] dat_r, dat_nxt;
  logic [LW-1:0] cur_r, cur_nxt, prev_r, prev_nxt, nxt_r, nxt_nxt;
  logic [LW-1:0] patch_r, patch_nxt, head_r, head_nxt, free_r, free_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic   match_r, match_nxt;
  logic [31:0] fdat_r, fdat_nxt;
  logic   rv_r, rv_nxt;
  logic [7:0] rrow_r, rrow_nxt, rcol_r, rcol_nxt;
  logic [31:0] rdat_r, rdat_nxt;
  logic   pend_v_r, pend_v_nxt;
  logic [15:0] pend_key_r, pend_key_nxt;
  logic [31:0] pend_dat_r, pend_dat_nxt;

  logic out_valid_r;
  stc_pkg::out_item_t out_r;
  logic emit;
  stc_pkg::out_item_t emit_item;
  logic slot_free;

  stc_pool u_pool (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;  op_nxt = op_r;  all_nxt = all_r;
    key_nxt = key_r;  dat_nxt = dat_r;  cur_nxt = cur_r;  prev_nxt = prev_r;
    nxt_nxt = nxt_r;  patch_nxt = patch_r;  head_nxt = head_r;
    free_nxt = free_r;  count_nxt = count_r;  match_nxt = match_r;
    fdat_nxt = fdat_r;  rv_nxt = rv_r;  rrow_nxt = rrow_r;  rcol_nxt = rcol_r;
    rdat_nxt = rdat_r;  pend_v_nxt = pend_v_r;  pend_key_nxt = pend_key_r;
    pend_dat_nxt = pend_dat_r;
    req = '0;
    emit = 1'b0;
    emit_item = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt = {in_data.row, in_data.col};
          dat_nxt = {in_data.note_code, in_data.velocity, in_data.effect,
                     in_data.effect_param};
          rrow_nxt = in_data.row;
          rcol_nxt = in_data.col;
          rdat_nxt = '0;
          rv_nxt = 1'b0;
          cur_nxt = head_r;
          prev_nxt = stc_pkg::LINK_NULL;
          match_nxt = 1'b0;
          pend_v_nxt = 1'b0;
          all_nxt = (in_data.mode == stc_pkg::MODE_LIST_ALL);
          state_nxt = stc_pkg::slot_ok(head_r) ? S_RD : S_DEC;
          case (in_data.mode)
            stc_pkg::MODE_LOOKUP: op_nxt = OP_LOOK;
            stc_pkg::MODE_SET: begin
              if (in_data.note_code == '0 && in_data.effect == '0 &&
                  in_data.effect_param == '0) begin
                // a clearing set succeeds whether or not the key was there
                op_nxt = OP_DEL;
                rv_nxt = 1'b1;
              end else begin
                op_nxt = OP_SET;
              end
            end
            stc_pkg::MODE_CLEAR: op_nxt = OP_DEL;
            stc_pkg::MODE_NEXT_ROW: op_nxt = OP_NEXT;
            stc_pkg::MODE_LIST_ROW, stc_pkg::MODE_LIST_ALL: op_nxt = OP_LIST;
            stc_pkg::MODE_CLEAR_ALL: begin
              req.lk_clear = 1'b1;
              head_nxt = stc_pkg::LINK_NULL;
              free_nxt = '0;
              count_nxt = '0;
              rv_nxt = 1'b1;
              rrow_nxt = '0;
              rcol_nxt = '0;
              state_nxt = S_RESP;
            end
            stc_pkg::MODE_COUNT: begin
              rv_nxt = 1'b1;
              rrow_nxt = '0;
              rcol_nxt = '0;
              state_nxt = S_RESP;
            end
            default: op_nxt = OP_LOOK;
          endcase
        end
      end

      S_RD: begin
        req.rd_en = 1'b1;
        req.rd_addr = cur_r[AW-1:0];
        state_nxt = S_CHK;
      end

      S_CHK: begin
        case (op_r)
          OP_NEXT: begin
            if (rsp.key[15:8] > key_r[15:8]) begin
              rv_nxt = 1'b1;
              rrow_nxt = rsp.key[15:8];
              rcol_nxt = '0;
              state_nxt = S_RESP;
            end else begin
              cur_nxt = rsp.link;
              state_nxt = stc_pkg::slot_ok(rsp.link) ? S_RD : S_DEC;
            end
          end
          OP_LIST: begin
            if (all_r || rsp.key[15:8] == key_r[15:8]) begin
              // hold while an earlier entry still waits for the output register
              if (!pend_v_r || slot_free) begin
                if (pend_v_r) begin
                  emit = 1'b1;
                  emit_item = {1'b1, pend_key_r, pend_dat_r, count_r, 1'b0};
                end
                pend_v_nxt = 1'b1;
                pend_key_nxt = rsp.key;
                pend_dat_nxt = rsp.data;
                cur_nxt = rsp.link;
                state_nxt = stc_pkg::slot_ok(rsp.link) ? S_RD : S_DEC;
              end
            end else if (rsp.key[15:8] > key_r[15:8]) begin
              state_nxt = S_DEC;
            end else begin
              cur_nxt = rsp.link;
              state_nxt = stc_pkg::slot_ok(rsp.link) ? S_RD : S_DEC;
            end
          end
          default: begin
            if (rsp.key < key_r) begin
              prev_nxt = cur_r;
              cur_nxt = rsp.link;
              state_nxt = stc_pkg::slot_ok(rsp.link) ? S_RD : S_DEC;
            end else begin
              match_nxt = (rsp.key == key_r);
              nxt_nxt = rsp.link;
              fdat_nxt = rsp.data;
              state_nxt = S_DEC;
            end
          end
        endcase
      end

      S_DEC: begin
        case (op_r)
          OP_LOOK: begin
            rv_nxt = match_r;
            rdat_nxt = match_r ? fdat_r : '0;
            state_nxt = S_RESP;
          end
          OP_NEXT: begin
            rv_nxt = 1'b0;
            rrow_nxt = stc_pkg::ROW_NONE;
            rcol_nxt = '0;
            state_nxt = S_RESP;
          end
          OP_LIST: begin
            if (slot_free) begin
              emit = 1'b1;
              if (pend_v_r) begin
                emit_item = {1'b1, pend_key_r, pend_dat_r, count_r, 1'b1};
              end else begin
                emit_item = {1'b0, 16'h0, 32'h0, count_r, 1'b1};
              end
              state_nxt = S_IDLE;
            end
          end
          OP_DEL: begin
            rv_nxt = rv_r || match_r;
            state_nxt = S_RESP;
            if (match_r) begin
              // return the slot to the free list, then unlink it
              req.lk_we = 1'b1;
              req.lk_addr = cur_r[AW-1:0];
              req.wr_link = free_r;
              free_nxt = cur_r;
              count_nxt = count_r - CW'(1);
              if (stc_pkg::slot_ok(prev_r)) begin
                patch_nxt = nxt_r;
                state_nxt = S_PATCH;
              end else begin
                head_nxt = nxt_r;
              end
            end
          end
          default: begin
            if (match_r) begin
              req.kd_we = 1'b1;
              req.kd_addr = cur_r[AW-1:0];
              req.wr_key = key_r;
              req.wr_data = dat_r;
              rv_nxt = 1'b1;
              state_nxt = S_RESP;
            end else if (!stc_pkg::slot_ok(free_r)) begin
              rv_nxt = 1'b0;
              state_nxt = S_RESP;
            end else begin
              req.rd_en = 1'b1;
              req.rd_addr = free_r[AW-1:0];
              state_nxt = S_FREE;
            end
          end
        endcase
      end

      S_FREE: begin
        free_nxt = rsp.link;
        req.kd_we = 1'b1;
        req.kd_addr = free_r[AW-1:0];
        req.wr_key = key_r;
        req.wr_data = dat_r;
        req.lk_we = 1'b1;
        req.lk_addr = free_r[AW-1:0];
        req.wr_link = cur_r;
        count_nxt = count_r + CW'(1);
        rv_nxt = 1'b1;
        if (stc_pkg::slot_ok(prev_r)) begin
          patch_nxt = free_r;
          state_nxt = S_PATCH;
        end else begin
          head_nxt = free_r;
          state_nxt = S_RESP;
        end
      end

      S_PATCH: begin
        req.lk_we = 1'b1;
        req.lk_addr = prev_r[AW-1:0];
        req.wr_link = patch_r;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (slot_free) begin
          emit = 1'b1;
          emit_item = {rv_r, rrow_r, rcol_r, rdat_r, count_r, 1'b1};
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= stc_pkg::LINK_NULL;
      free_r <= '0;
      count_r <= '0;
      pend_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      free_r <= free_nxt;
      count_r <= count_nxt;
      pend_v_r <= pend_v_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    op_r <= op_nxt;
    all_r <= all_nxt;
    key_r <= key_nxt;
    dat_r <= dat_nxt;
    cur_r <= cur_nxt;
    prev_r <= prev_nxt;
    nxt_r <= nxt_nxt;
    patch_r <= patch_nxt;
    match_r <= match_nxt;
    fdat_r <= fdat_nxt;
    rv_r <= rv_nxt;
    rrow_r <= rrow_nxt;
    rcol_r <= rcol_nxt;
    rdat_r <= rdat_nxt;
    pend_key_r <= pend_key_nxt;
    pend_dat_r <= pend_dat_nxt;
    if (emit) begin
      out_r <= emit_item;
    end
  end

  `STC_ASSERT_NOW(a_count_max, 1'b1, count_r <= CW'(stc_pkg::POOL_ENTRIES))
  `STC_ASSERT_NOW(a_free_vs_count, 1'b1,
                  stc_pkg::slot_ok(free_r) == (count_r < CW'(stc_pkg::POOL_ENTRIES)))
  `STC_ASSERT_NOW(a_head_vs_count, 1'b1,
                  (head_r == stc_pkg::LINK_NULL) == (count_r == '0))
  `STC_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)

endmodule
